// ----- rtl/lswp_pkg.sv -----
// Shared types and constants for the LIFO stack with peek.
package lswp_pkg;

  // Fixed field widths of the ports
  localparam int unsigned CmdW  = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 5;
  localparam int unsigned CapW  = 5;

  // Capacity after reset
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Command codes; codes 5 to 7 are no-ops
  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_TOP    = 3'd3,
    CMD_BOTTOM = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADPOS   = 2'd3
  } status_e;

  // Result info waiting for the memory read data
  typedef struct packed {
    status_e status;
    logic    full;
    logic    empty;
    logic    use_data;
  } pend_t;

endpackage

// ----- rtl/lswp_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module lswp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, or read into the output register; data holds between reads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lswp_ctrl.sv -----
// Command decode, entry count, capacity register and memory access stage.
module lswp_ctrl #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input transactions
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lswp_pkg::CmdW-1:0]     in_command_i,
  input  logic signed [lswp_pkg::DataW-1:0] in_value_i,
  input  logic [lswp_pkg::PosW-1:0]     in_position_i,
  // capacity register write
  input  logic                          cfg_valid_i,
  input  logic [lswp_pkg::CapW-1:0]     cfg_capacity_i,
  // memory port
  output logic                          ram_en_o,
  output logic                          ram_we_o,
  output logic [$clog2(DEPTH)-1:0]      ram_addr_o,
  output logic [WORD_WIDTH-1:0]         ram_wdata_o,
  // pending result toward the output buffer
  output logic                          pend_valid_o,
  output lswp_pkg::pend_t               pend_o,
  input  logic                          pend_take_i
);
  import lswp_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > PosW) ? ((CW > CapW) ? CW : CapW)
                                           : ((PosW > CapW) ? PosW : CapW);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [CW-1:0]   count_q, count_d;
  logic [CapW-1:0] cap_q;
  logic            pend_valid_q;
  pend_t           pend_q, pend_d;
  logic            accept;
  logic            empty_now, full_now;
  logic [MW-1:0]   cnt_m, pos_m, cap_m, cnt_d_m, peek_idx;
  logic [CW-1:0]   top_idx;
  cmd_e            cmd;

  assign in_stall_o = pend_valid_q && !pend_take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd        = cmd_e'(in_command_i);

  assign cnt_m     = MW'(count_q);
  assign pos_m     = MW'(in_position_i);
  assign cap_m     = MW'(cap_q);
  assign cnt_d_m   = MW'(count_d);
  assign peek_idx  = cnt_m - pos_m;
  assign top_idx   = count_q - CW'(1);
  assign empty_now = (count_q == '0);
  // full when the count reaches the capacity or the physical depth
  assign full_now  = (cnt_m >= cap_m) || (count_q == DepthC);

  assign ram_wdata_o = WORD_WIDTH'($unsigned(in_value_i));

  // Decode one command: next count, memory access, result status
  always_comb begin
    count_d         = count_q;
    ram_en_o        = 1'b0;
    ram_we_o        = 1'b0;
    ram_addr_o      = '0;
    pend_d.status   = ST_OK;
    pend_d.use_data = 1'b0;
    unique case (cmd)
      CMD_PUSH: begin
        if (full_now) begin
          pend_d.status = ST_OVERFLOW;
        end else begin
          ram_en_o   = accept;
          ram_we_o   = 1'b1;
          ram_addr_o = count_q[AW-1:0];
          count_d    = count_q + CW'(1);
        end
      end
      CMD_POP: begin
        if (empty_now) begin
          pend_d.status = ST_EMPTY;
        end else begin
          ram_en_o        = accept;
          ram_addr_o      = top_idx[AW-1:0];
          count_d         = top_idx;
          pend_d.use_data = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (empty_now) begin
          pend_d.status = ST_EMPTY;
        end else if ((pos_m == '0) || (pos_m > cnt_m)) begin
          pend_d.status = ST_BADPOS;
        end else begin
          ram_en_o        = accept;
          ram_addr_o      = peek_idx[AW-1:0];
          pend_d.use_data = 1'b1;
        end
      end
      CMD_TOP: begin
        if (empty_now) begin
          pend_d.status = ST_EMPTY;
        end else begin
          ram_en_o        = accept;
          ram_addr_o      = top_idx[AW-1:0];
          pend_d.use_data = 1'b1;
        end
      end
      CMD_BOTTOM: begin
        if (empty_now) begin
          pend_d.status = ST_EMPTY;
        end else begin
          ram_en_o        = accept;
          pend_d.use_data = 1'b1;
        end
      end
      default: begin
        // unknown command: no operation
      end
    endcase
    pend_d.full  = (cnt_d_m >= cap_m) || (count_d == DepthC);
    pend_d.empty = (count_d == '0);
  end

  // Count, capacity and pending-result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      cap_q        <= CapReset;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_capacity_i;
      end
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        pend_valid_q <= 1'b1;
      end else if (pend_take_i) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Pending result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

  assign pend_valid_o = pend_valid_q;
  assign pend_o       = pend_q;

endmodule

// ----- rtl/lswp_obuf.sv -----
// Output register: joins memory read data with the pending result.
module lswp_obuf #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pend_valid_i,
  input  lswp_pkg::pend_t                   pend_i,
  output logic                              pend_take_o,
  input  logic [WORD_WIDTH-1:0]             ram_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lswp_pkg::DataW-1:0] out_read_value_o,
  output logic [1:0]                        out_status_o,
  output logic                              out_is_full_o,
  output logic                              out_is_empty_o
);
  import lswp_pkg::*;

  logic             valid_q;
  logic             load;
  logic [DataW-1:0] word_ext;
  logic [DataW-1:0] value_q, value_d;
  status_e          status_q;
  logic             full_q, empty_q;

  // Register is free when empty or its transaction completes now
  assign load        = !valid_q || !out_stall_i;
  assign pend_take_o = pend_valid_i && load;

  // Sign-extend or truncate the stored word to the port width
  assign word_ext = DataW'($signed(ram_rdata_i));
  assign value_d  = pend_i.use_data ? word_ext : '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= pend_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_take_o) begin
      value_q  <= value_d;
      status_q <= pend_i.status;
      full_q   <= pend_i.full;
      empty_q  <= pend_i.empty;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_read_value_o = value_q;
  assign out_status_o     = status_q;
  assign out_is_full_o    = full_q;
  assign out_is_empty_o   = empty_q;

endmodule

// ----- rtl/lifo_stack_with_peek.sv -----
// Top level of the bounded LIFO stack with peek.
//
// Input channel (in_valid_i / in_stall_o): one command per transaction,
// push, pop, peek at a depth, read top or read bottom. Output channel
// (out_valid_o / out_stall_i): exactly one result per command, with the
// word read, a status code and the full and empty flags after the step.
// Configuration (cfg_valid_i / cfg_ready_o): writes the capacity; always
// ready. It must be written only while no command is in flight; the user
// keeps to this, as the block does not enforce it. An accepted command's
// result info enters the pending register and any word it reads enters the
// memory read register; the output register then loads both. One command per
// cycle while in_stall_o is low, each with at most one access to the one-port
// entry memory; the count updates at acceptance, so the next command sees it.
// Reset clears the count and sets the capacity to 16; the entry memory is
// not cleared, and no clearing pass runs. When the receiver stalls, the
// output register holds its result, one more result waits behind it, and
// then the input stalls until the output transaction completes.
module lifo_stack_with_peek #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lswp_pkg::CmdW-1:0]         in_command_i,
  input  logic signed [lswp_pkg::DataW-1:0] in_value_i,
  input  logic [lswp_pkg::PosW-1:0]         in_position_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lswp_pkg::DataW-1:0] out_read_value_o,
  output logic [1:0]                        out_status_o,
  output logic                              out_is_full_o,
  output logic                              out_is_empty_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lswp_pkg::CapW-1:0]         cfg_capacity_i
);
  import lswp_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic                  ram_en, ram_we;
  logic [AW-1:0]         ram_addr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                  pend_valid, pend_take;
  pend_t                 pend;
  logic                  cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Command stage
  lswp_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_command_i   (in_command_i),
    .in_value_i     (in_value_i),
    .in_position_i  (in_position_i),
    .cfg_valid_i    (cfg_wr),
    .cfg_capacity_i (cfg_capacity_i),
    .ram_en_o       (ram_en),
    .ram_we_o       (ram_we),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .pend_valid_o   (pend_valid),
    .pend_o         (pend),
    .pend_take_i    (pend_take)
  );

  // Entry memory
  lswp_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Result register
  lswp_obuf #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_obuf (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pend_valid_i     (pend_valid),
    .pend_i           (pend),
    .pend_take_o      (pend_take),
    .ram_rdata_i      (ram_rdata),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_read_value_o (out_read_value_o),
    .out_status_o     (out_status_o),
    .out_is_full_o    (out_is_full_o),
    .out_is_empty_o   (out_is_empty_o)
  );

endmodule

// ----- rtl/lswp_chk.sv -----
// Port-level checker for the LIFO stack, bound to the top level.
module lswp_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [lswp_pkg::DataW-1:0] out_read_value_o,
  input logic [1:0]                        out_status_o,
  input logic                              out_is_full_o,
  input logic                              out_is_empty_o
);
  import lswp_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_read_value_o)
      && $stable(out_status_o))
    else $error("stalled result changed");

  // Overflow leaves the stack full and returns all ones
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == ST_OVERFLOW) |->
      out_is_full_o && (out_read_value_o == -32'sd1))
    else $error("overflow result inconsistent");

  // Empty status means the stack is still empty
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == ST_EMPTY) |->
      out_is_empty_o && (out_read_value_o == -32'sd1))
    else $error("empty result inconsistent");

  // A bad peek position only happens on a non-empty stack
  a_badpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == ST_BADPOS) |->
      !out_is_empty_o && (out_read_value_o == -32'sd1))
    else $error("bad position result inconsistent");

endmodule

bind lifo_stack_with_peek lswp_chk u_lswp_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_read_value_o (out_read_value_o),
  .out_status_o     (out_status_o),
  .out_is_full_o    (out_is_full_o),
  .out_is_empty_o   (out_is_empty_o)
);
